// ===== design/majority_vote_descendant_match_core_defines.svh =====
// assertion macros used by the checker file
`ifndef MAJORITY_VOTE_DESCENDANT_MATCH_CORE_DEFINES_SVH
`define MAJORITY_VOTE_DESCENDANT_MATCH_CORE_DEFINES_SVH

// same-cycle implication
`define MVDM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MVDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mvdm_pkg.sv =====
`timescale 1ns / 1ps
package mvdm_pkg;

   localparam int MAP_ENTRIES = 65536;
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);
   localparam int GROUP_SLOTS = 4096;
   localparam int SLOT_W      = $clog2(GROUP_SLOTS);
   localparam int TC_W        = SLOT_W + 1;
   localparam int KEY_BITS    = 63;
   localparam int COUNT_BITS  = 24;
   localparam int SIZE_W      = 24;
   localparam int IDENT_W     = 64;
   localparam int ENTRY_W     = 1 + KEY_BITS + SLOT_W;
   localparam int REC_W       = IDENT_W + SIZE_W;
   localparam int HASH_SHIFT  = 29;

   localparam logic [63:0]           HASH_MULT = 64'h9E3779B97F4A7C15;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDENT_W-1:0]    NO_MATCH  = '1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_INSERT = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_H0, S_H1, S_H2, S_H3, S_PROBE_RD, S_PROBE_CHK,
      S_INS_OLD, S_INS_NEW, S_INS_CMP, S_VOTE_RD, S_VOTE_WR, S_RES_RD, S_RES,
      S_VCLR_RD, S_VCLR_WR, S_VCLR_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CAPTURE, CMD_CLR_STEP, CMD_H0, CMD_H1, CMD_H2, CMD_H3,
      CMD_PROBE_RD, CMD_PROBE_CHK, CMD_INS_OLD, CMD_INS_NEW, CMD_INS_CMP,
      CMD_VOTE_RD, CMD_VOTE_WR, CMD_RES_RD, CMD_RES_LOAD, CMD_VCLR_RD,
      CMD_VCLR_WR, CMD_VCLR_DONE
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic ent_valid;
      logic ent_match;
      logic probe_end;
      logic is_insert;
      logic last;
      logic tc_zero;
      logic vclr_last;
      logic rsp_busy;
   } status_type;

endpackage

// ===== design/majority_vote_descendant_match_core.sv =====
`timescale 1ns / 1ps
// majority vote descendant matcher
// req channel: one command per transfer (clear, load group record, insert
//   particle key, query particle key); rsp channel: one result per query
//   marked last_of_group, nothing for any other command
// load writes its group record on acceptance; insert and query pass S_H0
//   to S_H3 (one shared 32x32 multiplier builds the 64-bit product), a read
//   and a check state per linear probe step on the key map memory, then
//   S_INS_OLD to S_INS_CMP for an insert that hits an existing key or
//   S_VOTE_RD and S_VOTE_WR for a query that finds one; a last query adds
//   S_RES_RD, S_RES, a vote clear read and write per voted group, S_VCLR_DONE
// reset and the clear command start a sweep over all 65536 entries of the key
//   map and the vote store; no request is taken during the sweep
// the result sits in an output register: requests are taken while it waits,
//   and only the next result stalls until rsp_ready takes it
module majority_vote_descendant_match_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [mvdm_pkg::KEY_BITS-1:0]       req_particle_key,
   input  logic [mvdm_pkg::SLOT_W-1:0]         req_group_slot,
   input  logic signed [mvdm_pkg::IDENT_W-1:0] req_group_ident,
   input  logic [mvdm_pkg::SIZE_W-1:0]         req_group_size,
   input  logic                                req_last_of_group,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mvdm_pkg::IDENT_W-1:0] rsp_descendant_ident,
   output logic [mvdm_pkg::COUNT_BITS-1:0]     rsp_vote_total,
   output logic                                rsp_status
);
   import mvdm_pkg::*;

   cmd_type    cmd;
   status_type status;

   mvdm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_opcode(req_opcode),
      .status(status), .req_ready(req_ready), .cmd(cmd)
   );

   mvdm_datapath u_dp (
      .clock(clock), .reset(reset), .req_opcode(req_opcode),
      .req_particle_key(req_particle_key), .req_group_slot(req_group_slot),
      .req_group_ident(req_group_ident), .req_group_size(req_group_size),
      .req_last_of_group(req_last_of_group), .rsp_ready(rsp_ready), .cmd(cmd),
      .status(status), .rsp_valid(rsp_valid),
      .rsp_descendant_ident(rsp_descendant_ident),
      .rsp_vote_total(rsp_vote_total), .rsp_status(rsp_status)
   );
endmodule

// ===== design/mvdm_ram.sv =====
`timescale 1ns / 1ps
module mvdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/mvdm_datapath.sv =====
`timescale 1ns / 1ps
module mvdm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_opcode,
   input  logic [mvdm_pkg::KEY_BITS-1:0]     req_particle_key,
   input  logic [mvdm_pkg::SLOT_W-1:0]       req_group_slot,
   input  logic signed [mvdm_pkg::IDENT_W-1:0] req_group_ident,
   input  logic [mvdm_pkg::SIZE_W-1:0]       req_group_size,
   input  logic                              req_last_of_group,
   input  logic                              rsp_ready,
   input  mvdm_pkg::cmd_type                 cmd,
   output mvdm_pkg::status_type              status,
   output logic                              rsp_valid,
   output logic signed [mvdm_pkg::IDENT_W-1:0] rsp_descendant_ident,
   output logic [mvdm_pkg::COUNT_BITS-1:0]   rsp_vote_total,
   output logic                              rsp_status
);
   import mvdm_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  last_ff;
   logic                  insert_ff;
   logic [MAP_AW-1:0]     clr_idx_ff;
   logic [MAP_AW-1:0]     pos_ff;
   logic [MAP_AW-1:0]     steps_ff;
   logic [63:0]           mul_ff;
   logic [63:0]           acc_ff;
   logic [SLOT_W-1:0]     mslot_ff;
   logic [SIZE_W-1:0]     old_size_ff;
   logic [TC_W-1:0]       tc_ff;
   logic [TC_W-1:0]       vi_ff;
   logic [SLOT_W-1:0]     best_slot_ff;
   logic [COUNT_BITS-1:0] best_votes_ff;
   logic                  overflow_ff;
   logic                  rsp_valid_ff;
   logic [IDENT_W-1:0]    rsp_ident_ff;
   logic [COUNT_BITS-1:0] rsp_votes_ff;
   logic                  rsp_status_ff;

   logic [63:0]           key64;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           hash_in;
   logic [COUNT_BITS-1:0] vote_in;

   // memories
   logic                  map_we;
   logic [MAP_AW-1:0]     map_waddr;
   logic [ENTRY_W-1:0]    map_wdata;
   logic [ENTRY_W-1:0]    map_rdata;
   logic                  rec_we;
   logic [SLOT_W-1:0]     rec_raddr;
   logic [REC_W-1:0]      rec_rdata;
   logic                  vote_we;
   logic [SLOT_W-1:0]     vote_waddr;
   logic [COUNT_BITS-1:0] vote_wdata;
   logic [COUNT_BITS-1:0] vote_rdata;
   logic                  tl_we;
   logic [SLOT_W-1:0]     tl_rdata;

   logic                  ent_valid;
   logic [KEY_BITS-1:0]   ent_key;
   logic [SLOT_W-1:0]     ent_slot;
   logic                  ent_match;
   logic                  probe_end;
   logic                  empty_hit;
   logic                  full_hit;
   logic                  old_gt_new;
   logic                  rsp_busy;

   assign ent_valid  = map_rdata[ENTRY_W-1];
   assign ent_key    = map_rdata[ENTRY_W-2 -: KEY_BITS];
   assign ent_slot   = map_rdata[SLOT_W-1:0];
   assign ent_match  = ent_key == key_ff;
   assign probe_end  = steps_ff == '1;
   assign empty_hit  = !ent_valid;
   assign full_hit   = ent_valid && !ent_match && probe_end;
   assign old_gt_new = old_size_ff > rec_rdata[SIZE_W-1:0];
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign key64 = {{(64 - KEY_BITS){1'b0}}, key_ff};

   // one shared 32x32 multiplier for the 64-bit hash product
   always_comb begin
      mul_a = key64[31:0];
      mul_b = HASH_MULT[31:0];
      case (cmd)
         CMD_H1:  mul_b = HASH_MULT[63:32];
         CMD_H2:  mul_a = key64[63:32];
         default: ;
      endcase
   end

   assign hash_in = acc_ff + {mul_ff[31:0], 32'b0};
   assign vote_in = (vote_rdata == COUNT_MAX) ? vote_rdata : vote_rdata + 1'b1;

   always_comb begin
      map_we    = 1'b0;
      map_waddr = pos_ff;
      map_wdata = {1'b1, key_ff, slot_ff};
      if (cmd == CMD_CLR_STEP) begin
         map_we    = 1'b1;
         map_waddr = clr_idx_ff;
         map_wdata = '0;
      end else if (cmd == CMD_PROBE_CHK) begin
         map_we = insert_ff && empty_hit;
      end else if (cmd == CMD_INS_CMP) begin
         map_we = old_gt_new;
      end
   end

   assign rec_we = (cmd == CMD_CAPTURE) && (req_opcode == OP_LOAD);

   always_comb begin
      case (cmd)
         CMD_INS_OLD: rec_raddr = mslot_ff;
         CMD_INS_NEW: rec_raddr = slot_ff;
         default:     rec_raddr = best_slot_ff;
      endcase
   end

   always_comb begin
      vote_we    = 1'b0;
      vote_waddr = mslot_ff;
      vote_wdata = vote_in;
      case (cmd)
         CMD_CLR_STEP: begin
            vote_we    = 1'b1;
            vote_waddr = clr_idx_ff[SLOT_W-1:0];
            vote_wdata = '0;
         end
         CMD_VOTE_WR: vote_we = 1'b1;
         CMD_VCLR_WR: begin
            vote_we    = 1'b1;
            vote_waddr = tl_rdata;
            vote_wdata = '0;
         end
         default: ;
      endcase
   end

   // remember first-touched slots so only they are cleared after a result
   assign tl_we = (cmd == CMD_VOTE_WR) && (vote_rdata == '0) && !tc_ff[SLOT_W];

   mvdm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAP_ENTRIES)) u_map_ram (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(pos_ff), .rd_data(map_rdata)
   );

   mvdm_ram #(.WIDTH(REC_W), .DEPTH(GROUP_SLOTS)) u_rec_ram (
      .clock(clock), .wr_en(rec_we), .wr_addr(req_group_slot),
      .wr_data({req_group_ident, req_group_size}),
      .rd_addr(rec_raddr), .rd_data(rec_rdata)
   );

   mvdm_ram #(.WIDTH(COUNT_BITS), .DEPTH(GROUP_SLOTS)) u_vote_ram (
      .clock(clock), .wr_en(vote_we), .wr_addr(vote_waddr), .wr_data(vote_wdata),
      .rd_addr(mslot_ff), .rd_data(vote_rdata)
   );

   mvdm_ram #(.WIDTH(SLOT_W), .DEPTH(GROUP_SLOTS)) u_touch_ram (
      .clock(clock), .wr_en(tl_we), .wr_addr(tc_ff[SLOT_W-1:0]), .wr_data(mslot_ff),
      .rd_addr(vi_ff[SLOT_W-1:0]), .rd_data(tl_rdata)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd == CMD_CAPTURE) begin
         key_ff    <= req_particle_key;
         slot_ff   <= req_group_slot;
         last_ff   <= req_last_of_group;
         insert_ff <= req_opcode == OP_INSERT;
      end
      case (cmd)
         CMD_H0: mul_ff <= mul_a * mul_b;
         CMD_H1: begin
            acc_ff <= mul_ff;
            mul_ff <= mul_a * mul_b;
         end
         CMD_H2: begin
            acc_ff <= hash_in;
            mul_ff <= mul_a * mul_b;
         end
         CMD_H3: begin
            pos_ff   <= hash_in[MAP_AW-1:0] ^ hash_in[HASH_SHIFT +: MAP_AW];
            steps_ff <= '0;
         end
         CMD_PROBE_CHK: begin
            mslot_ff <= ent_slot;
            if (!empty_hit && !ent_match && !probe_end) begin
               pos_ff   <= pos_ff + 1'b1;
               steps_ff <= steps_ff + 1'b1;
            end
         end
         CMD_INS_NEW: old_size_ff <= rec_rdata[SIZE_W-1:0];
         default: ;
      endcase
      if (cmd == CMD_RES_LOAD) begin
         rsp_ident_ff  <= (best_votes_ff != '0) ? rec_rdata[REC_W-1 -: IDENT_W] : NO_MATCH;
         rsp_votes_ff  <= best_votes_ff;
         rsp_status_ff <= overflow_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset || (cmd == CMD_CAPTURE && req_opcode == OP_CLEAR)) begin
         clr_idx_ff    <= '0;
         tc_ff         <= '0;
         vi_ff         <= '0;
         best_slot_ff  <= '0;
         best_votes_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         if (cmd == CMD_CLR_STEP) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd == CMD_PROBE_CHK && insert_ff && full_hit) begin
            overflow_ff <= 1'b1;
         end
         if (cmd == CMD_VOTE_WR) begin
            if (tl_we) begin
               tc_ff <= tc_ff + 1'b1;
            end
            if (vote_in > best_votes_ff ||
                (vote_in == best_votes_ff && mslot_ff < best_slot_ff)) begin
               best_votes_ff <= vote_in;
               best_slot_ff  <= mslot_ff;
            end
         end
         if (cmd == CMD_VCLR_WR) begin
            vi_ff <= vi_ff + 1'b1;
         end
         if (cmd == CMD_VCLR_DONE) begin
            tc_ff         <= '0;
            vi_ff         <= '0;
            best_slot_ff  <= '0;
            best_votes_ff <= '0;
         end
      end
   end

   // a pending result may complete its transfer in the same cycle as a clear
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == CMD_RES_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.clr_done  = clr_idx_ff == '1;
      status.ent_valid = ent_valid;
      status.ent_match = ent_match;
      status.probe_end = probe_end;
      status.is_insert = insert_ff;
      status.last      = last_ff;
      status.tc_zero   = tc_ff == '0;
      status.vclr_last = vi_ff == (tc_ff - 1'b1);
      status.rsp_busy  = rsp_busy;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_descendant_ident = rsp_ident_ff;
   assign rsp_vote_total       = rsp_votes_ff;
   assign rsp_status           = rsp_status_ff;
endmodule

// ===== design/mvdm_ctrl.sv =====
`timescale 1ns / 1ps
module mvdm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   input  mvdm_pkg::status_type status,
   output logic                 req_ready,
   output mvdm_pkg::cmd_type    cmd
);
   import mvdm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode) inside
                  OP_CLEAR:              state_in = S_CLEAR;
                  OP_INSERT, OP_QUERY:   state_in = S_H0;
                  default:               state_in = S_IDLE;
               endcase
            end
         end
         S_H0:       state_in = S_H1;
         S_H1:       state_in = S_H2;
         S_H2:       state_in = S_H3;
         S_H3:       state_in = S_PROBE_RD;
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (status.ent_valid && status.ent_match) begin
               state_in = status.is_insert ? S_INS_OLD : S_VOTE_RD;
            end else if (!status.ent_valid || status.probe_end) begin
               state_in = (!status.is_insert && status.last) ? S_RES_RD : S_IDLE;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_INS_OLD:  state_in = S_INS_NEW;
         S_INS_NEW:  state_in = S_INS_CMP;
         S_INS_CMP:  state_in = S_IDLE;
         S_VOTE_RD:  state_in = S_VOTE_WR;
         S_VOTE_WR:  state_in = status.last ? S_RES_RD : S_IDLE;
         S_RES_RD:   state_in = S_RES;
         S_RES: begin
            if (!status.rsp_busy) state_in = status.tc_zero ? S_VCLR_DONE : S_VCLR_RD;
         end
         S_VCLR_RD:   state_in = S_VCLR_WR;
         S_VCLR_WR:   state_in = status.vclr_last ? S_VCLR_DONE : S_VCLR_RD;
         S_VCLR_DONE: state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = CMD_NONE;
      unique case (state_ff)
         S_CLEAR: cmd = CMD_CLR_STEP;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = CMD_CAPTURE;
         end
         S_H0:        cmd = CMD_H0;
         S_H1:        cmd = CMD_H1;
         S_H2:        cmd = CMD_H2;
         S_H3:        cmd = CMD_H3;
         S_PROBE_RD:  cmd = CMD_PROBE_RD;
         S_PROBE_CHK: cmd = CMD_PROBE_CHK;
         S_INS_OLD:   cmd = CMD_INS_OLD;
         S_INS_NEW:   cmd = CMD_INS_NEW;
         S_INS_CMP:   cmd = CMD_INS_CMP;
         S_VOTE_RD:   cmd = CMD_VOTE_RD;
         S_VOTE_WR:   cmd = CMD_VOTE_WR;
         S_RES_RD:    cmd = CMD_RES_RD;
         S_RES: begin
            if (!status.rsp_busy) cmd = CMD_RES_LOAD;
         end
         S_VCLR_RD:   cmd = CMD_VCLR_RD;
         S_VCLR_WR:   cmd = CMD_VCLR_WR;
         S_VCLR_DONE: cmd = CMD_VCLR_DONE;
         default:     cmd = CMD_NONE;
      endcase
   end
endmodule

// ===== design/mvdm_checker.sv =====
`timescale 1ns / 1ps
`include "majority_vote_descendant_match_core_defines.svh"
module mvdm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [mvdm_pkg::IDENT_W-1:0] rsp_descendant_ident
);
   // a waiting result holds
   `MVDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_descendant_ident), "result dropped or changed while stalled")
   // reset starts the clearing sweep with no result pending
   `MVDM_ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, !req_ready && !rsp_valid, "block not sweeping after reset")
   // a new result never follows a request transfer directly
   `MVDM_ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready), "result too soon after request")
endmodule

bind majority_vote_descendant_match_core mvdm_checker u_mvdm_checker (.*);
